/* rtl/first_match_pattern_search_top_macros.svh */
// ----------------------------------------------------------------------------
// first match pattern search - assertion macros
// shared property forms for the search block, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_PATTERN_SEARCH_TOP_MACROS_SVH
`define FIRST_MATCH_PATTERN_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define FMPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FMPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fmps_pkg.sv */
// ----------------------------------------------------------------------------
// fmps_pkg
// shared types and constants of the first match pattern search block
// ----------------------------------------------------------------------------
`default_nettype none

package fmps_pkg;

   // default sizes
   localparam int PATTERN_MAX_DEF = 16;
   localparam int TEXT_MAX_DEF    = 65536;

   // fixed field widths
   localparam int KIND_W    = 2;
   localparam int POS_W     = 4;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 17;
   localparam int LEN_CSR_W = 5;

   localparam logic [LEN_CSR_W-1:0] LEN_RESET  = LEN_CSR_W'(1);
   localparam logic [INDEX_W-1:0]   NONE_INDEX = {INDEX_W{1'b1}};

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // classified item handed from front to back
   typedef struct packed {
      logic                      is_pattern;
      logic                      is_text;
      logic                      is_restart;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } fmps_item_type;

endpackage

`default_nettype wire

/* rtl/fmps_front.sv */
// ----------------------------------------------------------------------------
// fmps_front
// accepts items, decodes their kind and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_match_pattern_search_top_macros.svh"

module fmps_front #(
   parameter int PATTERN_MAX = fmps_pkg::PATTERN_MAX_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [fmps_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [fmps_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [fmps_pkg::VALUE_W-1:0] req_value,
   output logic                                    q_valid,
   output fmps_pkg::fmps_item_type                 q_item,
   input  wire logic                               q_stall
);
   import fmps_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   fmps_item_type             dec_item;
   logic                      pos_ok;
   logic                      push;
   logic                      pop;

   fmps_item_type             q_data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         q_count_ff, q_count_in;

   // classify
   always_comb begin
      pos_ok              = (32'(req_position) < PATTERN_MAX);
      dec_item.is_pattern = 1'b0;
      dec_item.is_text    = 1'b0;
      dec_item.is_restart = 1'b0;
      dec_item.position   = req_position;
      dec_item.value      = req_value;
      unique case (req_kind)
         KIND_PATTERN: dec_item.is_pattern = pos_ok;
         KIND_TEXT:    dec_item.is_text    = 1'b1;
         KIND_RESTART: dec_item.is_restart = 1'b1;
         default:      ; // unused kind does nothing
      endcase
   end

   assign req_stall = (q_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (q_count_ff != '0);
   assign pop       = q_valid & ~q_stall;
   assign q_item    = q_data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push) begin
         wr_ptr_in = QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         q_count_in = QCNT_W'(q_count_ff + 1'b1);
      end else if (pop && !push) begin
         q_count_in = QCNT_W'(q_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= dec_item;
      end
   end

   `FMPS_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1,
      q_count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `FMPS_ASSERT_NEXT(a_queue_fills, clock, reset, push && !pop,
      q_valid, "pushed item not visible at queue head")

endmodule

`default_nettype wire

/* rtl/fmps_back.sv */
// ----------------------------------------------------------------------------
// fmps_back
// executes queued items: pattern store, text window compare, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_match_pattern_search_top_macros.svh"

module fmps_back #(
   parameter int PATTERN_MAX = fmps_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = fmps_pkg::TEXT_MAX_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_valid,
   input  wire fmps_pkg::fmps_item_type             q_item,
   output logic                                     q_stall,
   input  wire logic                                csr_wr_en,
   input  wire logic [fmps_pkg::LEN_CSR_W-1:0]      csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_match_here,
   output logic                                     rsp_found,
   output logic signed [fmps_pkg::INDEX_W-1:0]      rsp_first_index,
   output logic                                     rsp_overflow
);
   import fmps_pkg::*;

   localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W  = $clog2(TEXT_MAX + 1);
   localparam int DIFF_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic [LEN_CSR_W-1:0]      len_ff;
   logic [VALUE_W-1:0]        pattern_ff [PATTERN_MAX];
   logic [VALUE_W-1:0]        window_ff  [PATTERN_MAX];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [INDEX_W-1:0]        earliest_ff, earliest_in;
   logic                      seen_ff, seen_in;
   logic                      ovf_ff, ovf_in;

   logic                      out_vld_ff, out_vld_in;
   logic                      match_ff, here_in;
   logic                      found_ff;
   logic [INDEX_W-1:0]        first_ff;
   logic                      ovf_out_ff;

   logic                      take;
   logic [31:0]               len_wide;
   logic [31:0]               len_sel;
   logic [LEN_W-1:0]          used_len;
   logic [VALUE_W-1:0]        new_win [PATTERN_MAX];
   logic [LEN_W-1:0]          aidx    [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]    eq_vec;
   logic                      win_match;
   logic [CNT_W-1:0]          new_count;
   logic                      long_enough;
   logic [DIFF_W-1:0]         start_diff;
   logic                      text_full;
   logic                      pattern_we;
   logic [PIDX_W-1:0]         pattern_idx;
   logic                      window_we;

   assign q_stall = out_vld_ff & rsp_stall;
   assign take    = q_valid & ~q_stall;

   // length in use, clamped
   always_comb begin
      len_wide = 32'(len_ff);
      if (len_wide == 32'd0) begin
         len_sel = 32'd1;
      end else if (len_wide > 32'(PATTERN_MAX)) begin
         len_sel = 32'(PATTERN_MAX);
      end else begin
         len_sel = len_wide;
      end
      used_len = LEN_W'(len_sel);
   end

   // window after the shift, compared against the pattern in reverse order
   always_comb begin
      new_win[0] = q_item.value;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         new_win[i] = window_ff[i-1];
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         aidx[j]   = LEN_W'(used_len - LEN_W'(1) - LEN_W'(j));
         eq_vec[j] = (LEN_W'(j) >= used_len) ||
                     (new_win[j] == pattern_ff[aidx[j][PIDX_W-1:0]]);
      end
      win_match = &eq_vec;
   end

   assign text_full   = (count_ff == CNT_W'(TEXT_MAX));
   assign new_count   = CNT_W'(count_ff + CNT_W'(1));
   assign long_enough = (DIFF_W'(new_count) >= DIFF_W'(used_len));
   assign start_diff  = DIFF_W'(new_count) - DIFF_W'(used_len);
   assign pattern_we  = take & q_item.is_pattern;
   assign pattern_idx = PIDX_W'(q_item.position);
   assign window_we   = take & q_item.is_text & ~text_full;

   always_comb begin
      count_in    = count_ff;
      earliest_in = earliest_ff;
      seen_in     = seen_ff;
      ovf_in      = ovf_ff;
      here_in     = 1'b0;
      if (take) begin
         priority if (q_item.is_restart) begin
            count_in    = '0;
            earliest_in = NONE_INDEX;
            seen_in     = 1'b0;
            ovf_in      = 1'b0;
         end else if (q_item.is_text) begin
            if (text_full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = new_count;
               if (long_enough && win_match) begin
                  here_in = 1'b1;
                  if (!seen_ff) begin
                     seen_in     = 1'b1;
                     earliest_in = start_diff[INDEX_W-1:0];
                  end
               end
            end
         end else begin
            // pattern write or unused kind: search state unchanged
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (take) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_RESET;
         count_ff    <= '0;
         earliest_ff <= NONE_INDEX;
         seen_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         count_ff    <= count_in;
         earliest_ff <= earliest_in;
         seen_ff     <= seen_in;
         ovf_ff      <= ovf_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (pattern_we) begin
         pattern_ff[pattern_idx] <= q_item.value;
      end
      if (window_we) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            window_ff[i] <= new_win[i];
         end
      end
      if (take) begin
         match_ff   <= here_in;
         found_ff   <= seen_in;
         first_ff   <= earliest_in;
         ovf_out_ff <= ovf_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_match_here  = match_ff;
   assign rsp_found       = found_ff;
   assign rsp_first_index = first_ff;
   assign rsp_overflow    = ovf_out_ff;

   `FMPS_ASSERT_IMPL(a_none_until_seen, clock, reset, !seen_ff,
      earliest_ff == NONE_INDEX, "first index set without a match")
   `FMPS_ASSERT_NEXT(a_first_held, clock, reset,
      seen_ff && !(take && q_item.is_restart),
      $stable(earliest_ff), "first index moved after a match")
   `FMPS_ASSERT_IMPL(a_overflow_full, clock, reset, ovf_ff,
      count_ff == CNT_W'(TEXT_MAX), "overflow flagged below text limit")

endmodule

`default_nettype wire

/* rtl/first_match_pattern_search_top.sv */
// ----------------------------------------------------------------------------
// first_match_pattern_search_top
// lowest start index of a pattern of 32-bit words in a stream of text words
// ----------------------------------------------------------------------------
//
//   channel  ports           dir  payload
//   -------  --------------  ---  ------------------------------------------
//   req      req_valid/stall in   kind, position, value
//   rsp      rsp_valid/stall out  match_here, found, first_index, overflow
//   csr      csr_wr_en       in   pattern_length (5 bits)
//
// one item per clock sustained while rsp is not stalled; every item gives one result item
// path: queue write, then compare and result register
// the window compare of all positions is combinational in the back end
// reset is synchronous and active high; no clearing pass is needed
// a stalled rsp fills the two-entry queue before req_stall rises
//
`default_nettype none

module first_match_pattern_search_top #(
   parameter int PATTERN_MAX = fmps_pkg::PATTERN_MAX_DEF,
   parameter int TEXT_MAX    = fmps_pkg::TEXT_MAX_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input items
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [fmps_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [fmps_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [fmps_pkg::VALUE_W-1:0]  req_value,
   // pattern length register
   input  wire logic                                 csr_wr_en,
   input  wire logic [fmps_pkg::LEN_CSR_W-1:0]       csr_wr_data,
   // result items
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_match_here,
   output logic                                      rsp_found,
   output logic signed [fmps_pkg::INDEX_W-1:0]       rsp_first_index,
   output logic                                      rsp_overflow
);
   import fmps_pkg::*;

   // classified item between front and back
   logic          q_valid;
   logic          q_stall;
   fmps_item_type q_item;

   // front: decode kind, range-check the pattern position, queue the item
   fmps_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_value    (req_value),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_stall      (q_stall)
   );

   // back: pattern store, sliding window, match tracking, result register
   fmps_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_stall         (q_stall),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_here  (rsp_match_here),
      .rsp_found       (rsp_found),
      .rsp_first_index (rsp_first_index),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

`default_nettype wire
